FILE: hw/rtl/shamd_pkg.sv
// shared types, constants and round functions for the sha-256 digest unit
// no dependencies
`default_nettype none

package shamd_pkg;

   localparam int unsigned WORD_WIDTH   = 32;
   localparam int unsigned CHAIN_WORDS  = 8;
   localparam int unsigned BLOCK_BYTES  = 64;
   localparam int unsigned SCHED_WORDS  = 16;
   localparam int unsigned LENGTH_WIDTH = 61;
   localparam int unsigned FILL_WIDTH   = 6;
   localparam int unsigned ROUND_WIDTH  = 6;
   localparam int unsigned INDEX_WIDTH  = 3;

   localparam logic [7:0] PAD_MARKER = 8'h80;
   localparam logic [FILL_WIDTH-1:0] FILL_LAST   = 6'd63;
   localparam logic [FILL_WIDTH-1:0] FILL_LENGTH = 6'd56;
   localparam logic [ROUND_WIDTH-1:0] ROUND_LAST = 6'd63;
   localparam logic [INDEX_WIDTH-1:0] WORD_LAST  = 3'd7;

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef logic [CHAIN_WORDS-1:0][WORD_WIDTH-1:0] chain_type;

   localparam chain_type INITIAL_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   // source of the byte shifted into the block
   typedef enum logic [1:0] {
      BYTE_INPUT,
      BYTE_MARKER,
      BYTE_ZERO,
      BYTE_LENGTH
   } byte_sel_type;

   typedef struct packed {
      logic                   push;
      byte_sel_type           byte_sel;
      logic                   count_byte;
      logic                   start_block;
      logic                   round_en;
      logic [ROUND_WIDTH-1:0] round_idx;
      logic                   finish_block;
      logic                   restart;
      logic [INDEX_WIDTH-1:0] word_sel;
   } shamd_cmd_type;

   typedef struct packed {
      logic [FILL_WIDTH-1:0] fill;
   } shamd_status_type;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (WORD_WIDTH - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type round_k(input logic [ROUND_WIDTH-1:0] idx);
      word_type k;
      case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/shamd_req_if.sv
// request channel of the digest unit: one message byte and its flags per transfer
// depends on nothing
`default_nettype none

interface shamd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, data_byte, byte_present, end_of_message, input ready);
   modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/shamd_rsp_if.sv
// response channel of the digest unit: one digest word per transfer
// depends on nothing
`default_nettype none

interface shamd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sha256_message_digest_unit.sv
// SHA-256 message digest unit, top level
// Usage:
//   req_channel carries one message byte per transfer, with byte_present set
//   when data_byte is part of the message and end_of_message on the final
//   transfer. A transfer with end_of_message pads the message, finishes it
//   and then sends the digest on rsp_channel as eight 32-bit words, word 0
//   (most significant) first, last_word set on word 7.
//   The 64th byte of a block starts its compression: one round a cycle in the
//   round unit, then the chaining add. The final transfer is followed by the
//   padding bytes (9 to 72) and the compression of each padded block (one or
//   two), then by the eight digest transfers on rsp_channel.
//   req_channel.ready is low from the final transfer until the eighth digest
//   word is taken; a stalled rsp_channel holds the current word.
//   Reset clears the byte count and fill and loads the initial hash values;
//   the unit returns to the same state after each digest.
// Depends on shamd_pkg, shamd_req_if, shamd_rsp_if, shamd_ctrl, shamd_datapath.
`default_nettype none

module sha256_message_digest_unit (
   input  wire logic    clock,
   input  wire logic    reset,
   shamd_req_if.sink    req_channel,
   shamd_rsp_if.source  rsp_channel
);
   import shamd_pkg::*;

   shamd_cmd_type    cmd;
   shamd_status_type status;

   shamd_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_channel.valid),
      .req_ready          (req_channel.ready),
      .req_byte_present   (req_channel.byte_present),
      .req_end_of_message (req_channel.end_of_message),
      .rsp_valid          (rsp_channel.valid),
      .rsp_ready          (rsp_channel.ready),
      .cmd                (cmd),
      .status             (status)
   );

   shamd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_data_byte   (req_channel.data_byte),
      .rsp_digest_word (rsp_channel.digest_word),
      .rsp_word_index  (rsp_channel.word_index),
      .rsp_last_word   (rsp_channel.last_word)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/shamd_ctrl.sv
// controller of the digest unit: absorb, compression rounds, padding, digest output
// depends on shamd_pkg
`default_nettype none

module shamd_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_byte_present,
   input  wire logic                        req_end_of_message,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output shamd_pkg::shamd_cmd_type         cmd,
   input  wire shamd_pkg::shamd_status_type status
);
   import shamd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINISH,
      ST_PAD,
      ST_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      PH_MARKER,
      PH_ZERO,
      PH_LENGTH
   } phase_type;

   state_type              state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic                   ending_ff, ending_in;
   logic                   len_done_ff, len_done_in;
   logic [ROUND_WIDTH-1:0] round_ff, round_in;
   logic [INDEX_WIDTH-1:0] word_ff, word_in;
   logic                   fill_last;

   assign fill_last = (status.fill == FILL_LAST);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUTPUT);

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      ending_in   = ending_ff;
      len_done_in = len_done_ff;
      round_in    = round_ff;
      word_in     = word_ff;
      cmd         = '0;
      cmd.byte_sel  = BYTE_INPUT;
      cmd.round_idx = round_ff;
      cmd.word_sel  = word_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ending_in   = req_end_of_message;
               len_done_in = 1'b0;
               phase_in    = PH_MARKER;
               if (req_byte_present) begin
                  cmd.push       = 1'b1;
                  cmd.count_byte = 1'b1;
                  if (fill_last) begin
                     cmd.start_block = 1'b1;
                     round_in        = '0;
                     state_in        = ST_ROUND;
                  end else if (req_end_of_message) begin
                     state_in = ST_PAD;
                  end
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 1'b1;
            if (round_ff == ROUND_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish_block = 1'b1;
            if (!ending_ff) begin
               state_in = ST_IDLE;
            end else if (len_done_ff) begin
               word_in  = '0;
               state_in = ST_OUTPUT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            cmd.push = 1'b1;
            unique case (phase_ff)
               PH_MARKER: begin
                  cmd.byte_sel = BYTE_MARKER;
                  phase_in     = PH_ZERO;
               end
               PH_ZERO: begin
                  // zeros until byte 56 of a block, then the bit length
                  if (status.fill == FILL_LENGTH) begin
                     cmd.byte_sel = BYTE_LENGTH;
                     phase_in     = PH_LENGTH;
                  end else begin
                     cmd.byte_sel = BYTE_ZERO;
                  end
               end
               PH_LENGTH: begin
                  cmd.byte_sel = BYTE_LENGTH;
               end
               default: begin
                  cmd.byte_sel = BYTE_ZERO;
               end
            endcase
            if (fill_last) begin
               cmd.start_block = 1'b1;
               round_in        = '0;
               len_done_in     = (phase_ff == PH_LENGTH);
               state_in        = ST_ROUND;
            end
         end
         ST_OUTPUT: begin
            if (rsp_ready) begin
               word_in = word_ff + 1'b1;
               if (word_ff == WORD_LAST) begin
                  cmd.restart = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= PH_MARKER;
         ending_ff   <= 1'b0;
         len_done_ff <= 1'b0;
         round_ff    <= '0;
         word_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         ending_ff   <= ending_in;
         len_done_ff <= len_done_in;
         round_ff    <= round_in;
         word_ff     <= word_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/shamd_datapath.sv
// datapath of the digest unit: block shift line, message schedule, round
// registers, chaining words and byte count; depends on shamd_pkg
`default_nettype none

module shamd_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire shamd_pkg::shamd_cmd_type   cmd,
   output shamd_pkg::shamd_status_type     status,
   input  wire logic [7:0]                 req_data_byte,
   output logic [shamd_pkg::WORD_WIDTH-1:0]  rsp_digest_word,
   output logic [shamd_pkg::INDEX_WIDTH-1:0] rsp_word_index,
   output logic                            rsp_last_word
);
   import shamd_pkg::*;

   // block bytes and then the message schedule share one 16-word shift line
   word_type                w_ff [SCHED_WORDS];
   chain_type               chain_ff;
   chain_type               v_ff;
   logic [LENGTH_WIDTH-1:0] len_ff;
   logic [FILL_WIDTH-1:0]   fill_ff;

   logic [7:0]  push_byte;
   logic [63:0] bit_length;
   word_type    new_w, t1, t2;

   assign bit_length = {len_ff, 3'b000};
   assign status.fill = fill_ff;

   always_comb begin
      case (cmd.byte_sel)
         BYTE_INPUT:  push_byte = req_data_byte;
         BYTE_MARKER: push_byte = PAD_MARKER;
         BYTE_LENGTH: push_byte = 8'(bit_length >> (7'd56 - {1'b0, fill_ff[2:0], 3'b000}));
         default:     push_byte = 8'h00;
      endcase
   end

   assign new_w = w_ff[0] + small_sigma0(w_ff[1]) + w_ff[9] + small_sigma1(w_ff[14]);

   // v_ff[0] is a, v_ff[7] is h
   assign t1 = v_ff[7] + big_sigma1(v_ff[4])
             + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + round_k(cmd.round_idx) + w_ff[0];
   assign t2 = big_sigma0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         for (int i = 0; i < SCHED_WORDS - 1; i++) begin
            w_ff[i] <= {w_ff[i][WORD_WIDTH-9:0], w_ff[i+1][WORD_WIDTH-1 -: 8]};
         end
         w_ff[SCHED_WORDS-1] <= {w_ff[SCHED_WORDS-1][WORD_WIDTH-9:0], push_byte};
      end else if (cmd.round_en) begin
         for (int i = 0; i < SCHED_WORDS - 1; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[SCHED_WORDS-1] <= new_w;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_block) begin
         v_ff <= chain_ff;
      end else if (cmd.round_en) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         chain_ff <= INITIAL_HASH;
         len_ff   <= '0;
         fill_ff  <= '0;
      end else begin
         if (cmd.finish_block) begin
            for (int i = 0; i < CHAIN_WORDS; i++) begin
               chain_ff[i] <= chain_ff[i] + v_ff[i];
            end
         end
         if (cmd.count_byte) begin
            len_ff <= len_ff + 1'b1;
         end
         if (cmd.push) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   assign rsp_digest_word = chain_ff[cmd.word_sel];
   assign rsp_word_index  = cmd.word_sel;
   assign rsp_last_word   = (cmd.word_sel == WORD_LAST);

endmodule

`default_nettype wire

FILE: tb/sv/sha256_message_digest_unit_checker.sv
// digest checker: watches both channels, keeps its own sha-256 state and compares every digest word
// depends on shamd_req_if and shamd_rsp_if
`default_nettype none

module sha256_message_digest_unit_checker (
   input  wire logic clock,
   input  wire logic reset,
   shamd_req_if      req_mon,
   shamd_rsp_if      rsp_mon,
   output int        failures,
   output int        outstanding,
   output int        words_checked
);

   localparam logic [0:63][31:0] ROUND_CONST = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [0:7][31:0] START_HASH = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] MARKER_BYTE = 8'h80;
   localparam int unsigned LENGTH_SLOT = 56;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_word_type;

   logic [0:7][31:0]  chain_acc;
   logic [0:63][7:0]  block_store;
   logic [60:0]       byte_count;
   logic [6:0]        block_fill;
   digest_word_type   expected_words [$];
   int                fail_tally = 0;
   int                checked_tally = 0;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void restart_hash();
      chain_acc  = START_HASH;
      byte_count = '0;
      block_fill = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] sched [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      int i;
      for (i = 0; i < 16; i++)
         sched[i] = {block_store[4*i], block_store[4*i+1], block_store[4*i+2], block_store[4*i+3]};
      for (i = 16; i < 64; i++) begin
         s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
         s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
         sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
      end
      for (i = 0; i < 8; i++)
         v[i] = chain_acc[i];
      for (i = 0; i < 64; i++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + sched[i];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (i = 0; i < 8; i++)
         chain_acc[i] = chain_acc[i] + v[i];
   endfunction

   function automatic void absorb_byte(input logic [7:0] b);
      block_store[block_fill[5:0]] = b;
      block_fill = block_fill + 7'd1;
      if (block_fill == 7'd64) begin
         compress_block();
         block_fill = '0;
      end
   endfunction

   // pad, append the bit length, queue the eight digest words and restart the hash state
   function automatic void close_message();
      logic [63:0] bit_length;
      digest_word_type w;
      int i;
      bit_length = {byte_count, 3'b000};
      absorb_byte(MARKER_BYTE);
      while (block_fill != LENGTH_SLOT)
         absorb_byte(8'h00);
      for (i = 0; i < 8; i++)
         absorb_byte(bit_length[63 - 8*i -: 8]);
      for (i = 0; i < 8; i++) begin
         w.digest_word = chain_acc[i];
         w.word_index  = i[2:0];
         w.last_word   = (i == 7);
         expected_words.push_back(w);
      end
      restart_hash();
   endfunction

   always @(posedge clock) begin
      digest_word_type want;
      if (reset) begin
         restart_hash();
         expected_words.delete();
      end else begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            if (req_mon.byte_present) begin
               byte_count = byte_count + 61'd1;
               absorb_byte(req_mon.data_byte);
            end
            if (req_mon.end_of_message)
               close_message();
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_words.size() == 0) begin
               fail_tally++;
               $display("%0t: unexpected digest transfer, expected none, got word %h index %0d",
                        $time, rsp_mon.digest_word, rsp_mon.word_index);
            end else begin
               want = expected_words.pop_front();
               checked_tally++;
               if (rsp_mon.digest_word !== want.digest_word) begin
                  fail_tally++;
                  $display("%0t: digest_word mismatch, expected %h, got %h",
                           $time, want.digest_word, rsp_mon.digest_word);
               end
               if (rsp_mon.word_index !== want.word_index) begin
                  fail_tally++;
                  $display("%0t: word_index mismatch, expected %0d, got %0d",
                           $time, want.word_index, rsp_mon.word_index);
               end
               if (rsp_mon.last_word !== want.last_word) begin
                  fail_tally++;
                  $display("%0t: last_word mismatch, expected %b, got %b",
                           $time, want.last_word, rsp_mon.last_word);
               end
            end
         end
      end
      outstanding   <= expected_words.size();
      failures      <= fail_tally;
      words_checked <= checked_tally;
   end

endmodule

`default_nettype wire

FILE: tb/sv/sha256_message_digest_unit_tb.sv
// testbench top for the sha-256 digest unit: clock, reset, message stimulus and verdict
// depends on the unit, shamd_req_if, shamd_rsp_if and sha256_message_digest_unit_checker
`default_nettype none

module sha256_message_digest_unit_tb;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned ITEM_TARGET  = 270;
   localparam int unsigned DRAIN_CYCLES = 250;
   localparam int unsigned IDLE_PERCENT = 31;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        calm = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned byte_transfers = 0;
   int unsigned messages_sent = 0;
   int unsigned counted_items = 0;
   int          failures;
   int          outstanding;
   int          words_checked;

   shamd_req_if req_channel();
   shamd_rsp_if rsp_channel();

   sha256_message_digest_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_channel),
      .rsp_channel (rsp_channel)
   );

   sha256_message_digest_unit_checker digest_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_channel),
      .rsp_mon       (rsp_channel),
      .failures      (failures),
      .outstanding   (outstanding),
      .words_checked (words_checked)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_channel.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[sha256_message_digest_unit] ERROR");
         $finish;
      end
   end

   // valid stays up from one transfer to the next unless a gap is drawn
   task automatic send_item(input logic [7:0] data, input logic present, input logic ending);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_channel.valid <= 1'b0;
         @(posedge clock);
      end
      req_channel.valid          <= 1'b1;
      req_channel.data_byte      <= data;
      req_channel.byte_present   <= present;
      req_channel.end_of_message <= ending;
      @(posedge clock);
      while (req_channel.ready !== 1'b1)
         @(posedge clock);
      counted_items++;
      if (present)
         byte_transfers++;
      if (ending)
         messages_sent++;
   endtask

   // random content; the end flag rides on the last byte or on a transfer of its own
   task automatic send_message(input int unsigned len, input bit end_on_byte);
      int unsigned i;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 8)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
      end
      if (!end_on_byte || len == 0) begin
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
   endtask

   initial begin
      int unsigned len;
      req_channel.valid          <= 1'b0;
      req_channel.data_byte      <= 8'h00;
      req_channel.byte_present   <= 1'b0;
      req_channel.end_of_message <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty message, then a transfer with neither flag
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hff, 1'b0, 1'b0);
      // "abc" closed by an end transfer without a byte
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b0);
      send_item(8'hff, 1'b0, 1'b1);
      // one-byte messages where the byte and the end share a transfer
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      // ignored transfer in the middle of a message
      send_item(8'h5a, 1'b1, 1'b0);
      send_item(8'h3c, 1'b0, 1'b0);
      send_item(8'ha5, 1'b1, 1'b1);
      // back-to-back empty messages
      send_item(8'haa, 1'b0, 1'b1);
      send_item(8'h55, 1'b0, 1'b1);

      while (counted_items < ITEM_TARGET) begin
         calm <= (counted_items >= 90) && (counted_items < 170);
         if ($urandom_range(0, 99) < 60)
            len = $urandom_range(0, 12);
         else
            case ($urandom_range(0, 5))
               0: len = 55;
               1: len = 56;
               2: len = 57;
               3: len = 63;
               4: len = 64;
               default: len = 65;
            endcase
         // keep the last message within the item budget
         if (len + 1 > ITEM_TARGET - counted_items)
            len = ITEM_TARGET - counted_items - 1;
         send_message(len, 1'($urandom_range(0, 1)));
      end
      calm <= 1'b0;
      req_channel.valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d messages built from %0d byte transfers, with gaps on both sides",
               messages_sent, byte_transfers);
      $display("compared %0d digest words against the local sha-256 model", words_checked);
      if (failures == 0 && outstanding == 0)
         $display("[sha256_message_digest_unit] OK");
      else
         $display("[sha256_message_digest_unit] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
